@@ rtl/hbfa_pkg.sv @@
// ----------------------------------------------------------------------------
// hbfa_pkg: shared constants and helpers for the bitmap frame allocator
// Operation and status codes, map geometry and a trailing-zero count.
// ----------------------------------------------------------------------------
package hbfa_pkg;

	localparam int unsigned PAGE_SHIFT = 12;
	localparam int unsigned CFG_INDEX_W = 4;
	localparam int unsigned CFG_REGS = 8;
	localparam logic [18:0] FRAMES_MAX = 19'd262144;

	localparam logic [1:0] FUNC_ALLOC = 2'd0;
	localparam logic [1:0] FUNC_FREE = 2'd1;
	localparam logic [1:0] FUNC_USED = 2'd2;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_NO_FREE = 3'd1;
	localparam logic [2:0] ST_MISALIGNED = 3'd2;
	localparam logic [2:0] ST_OUTSIDE = 3'd3;
	localparam logic [2:0] ST_PAST_END = 3'd4;

	// Index of the lowest set bit; 64 when the word is empty.
	function automatic logic [6:0] ctz64(input logic [63:0] v);
		logic [6:0] n;
		n = 7'd64;
		for (int i = 63; i >= 0; i--) begin
			if (v[i]) begin
				n = 7'(i);
			end
		end
		return n;
	endfunction

endpackage

@@ rtl/hbfa_if.sv @@
// ----------------------------------------------------------------------------
// hbfa_if: valid/ready channels of the frame allocator
// Request, response and register write channels.
// ----------------------------------------------------------------------------
interface hbfa_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [63:0] byte_address;
	logic [18:0] frame_count;

	modport source(output valid, func, byte_address, frame_count, input ready);
	modport sink(input valid, func, byte_address, frame_count, output ready);
endinterface

interface hbfa_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [63:0] granted_address;
	logic [6:0]  granted_frames;

	modport source(output valid, status, granted_address, granted_frames, input ready);
	modport sink(input valid, status, granted_address, granted_frames, output ready);
endinterface

interface hbfa_cfg_if;
	logic        valid;
	logic        ready;
	logic [3:0]  index;
	logic [63:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/hbfa_ram.sv @@
// ----------------------------------------------------------------------------
// hbfa_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hbfa_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/hierarchical_bitmap_frame_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// hierarchical_bitmap_frame_allocator_unit: three-level bitmap page allocator
// Top words in flops, mid and leaf words in RAMs, one request at a time.
// ----------------------------------------------------------------------------
// Allocate: the chained mid and leaf RAM reads, the run-length step and the writeback,
// in that order, all skipped when nothing is free.
// Free / mark used: a containment check over every region, then for each holding region
// one read and one writeback on both RAMs per frame; early rejects skip all of it.
// One request in flight; a new one is taken once the previous result is queued.
// Reset clears registers and top words; stored mid/leaf words count only when
// their parent bit is set, so every map reads empty at once with no clear pass.
module hierarchical_bitmap_frame_allocator_unit
	import hbfa_pkg::*;
#(
	parameter int unsigned REGIONS = 4
) (
	input logic clk,
	input logic arst_n,
	hbfa_cfg_if.sink   cfg,
	hbfa_req_if.sink   req,
	hbfa_rsp_if.source rsp
);

	localparam int unsigned RW = (REGIONS > 1) ? $clog2(REGIONS) : 1;
	localparam int unsigned MID_DEPTH = REGIONS * 64;
	localparam int unsigned LEAF_DEPTH = REGIONS * 4096;
	localparam int unsigned MAW = $clog2(MID_DEPTH);
	localparam int unsigned LAW = $clog2(LEAF_DEPTH);
	localparam logic [RW-1:0] REG_LAST = RW'(REGIONS - 1);

	typedef enum logic [10:0] {
		S_IDLE    = 11'b00000000001,
		S_CHK     = 11'b00000000010,
		S_CHK_END = 11'b00000000100,
		S_RUN_SEL = 11'b00000001000,
		S_RUN_RD  = 11'b00000010000,
		S_RUN_WB  = 11'b00000100000,
		S_A_MID   = 11'b00001000000,
		S_A_LEAF  = 11'b00010000000,
		S_A_O3    = 11'b00100000000,
		S_A_RUN   = 11'b01000000000,
		S_DONE    = 11'b10000000000
	} state_t;

	state_t state_q;

	logic [63:0] base_q [REGIONS];
	logic [18:0] frames_q [REGIONS];
	logic [63:0] top_q [REGIONS];

	logic [1:0]  func_q;
	logic [63:0] addr_q;
	logic [18:0] count_q;
	logic [RW-1:0] reg_q;
	logic [REGIONS-1:0] holds_q;
	logic [17:0] frame_q [REGIONS];
	logic [17:0] cur_q;
	logic [18:0] left_q;

	logic [5:0]  o1_q, o2_q, o3_q;
	logic [63:0] m2_q, m3_q;
	logic [6:0]  n_q;

	logic [2:0]  res_status_q;
	logic [63:0] res_addr_q;
	logic [6:0]  res_frames_q;

	logic        out_valid_q;
	logic [2:0]  out_status_q;
	logic [63:0] out_addr_q;
	logic [6:0]  out_frames_q;

	// Allocate writeback is the first DONE cycle of a successful allocate
	logic alloc_wb;
	logic alloc_wb_q;
	assign alloc_wb = alloc_wb_q;

	// RAM ports
	logic           mid_we, leaf_we;
	logic [MAW-1:0] mid_waddr, mid_raddr;
	logic [LAW-1:0] leaf_waddr, leaf_raddr;
	logic [63:0]    mid_wdata, leaf_wdata, mid_rd, leaf_rd;

	hbfa_ram #(.WIDTH(64), .DEPTH(MID_DEPTH)) u_mid_ram (
		.clk(clk), .we(mid_we), .waddr(mid_waddr), .wdata(mid_wdata),
		.raddr(mid_raddr), .rdata(mid_rd)
	);

	hbfa_ram #(.WIDTH(64), .DEPTH(LEAF_DEPTH)) u_leaf_ram (
		.clk(clk), .we(leaf_we), .waddr(leaf_waddr), .wdata(leaf_wdata),
		.raddr(leaf_raddr), .rdata(leaf_rd)
	);

	// Region choice for allocate: highest region with anything free
	logic [RW-1:0] rsel;
	logic          any_free;
	logic [6:0]    o1_ctz;
	always_comb begin
		rsel = '0;
		any_free = 1'b0;
		for (int r = 0; r < REGIONS; r++) begin
			if (top_q[r] != 64'd0) begin
				rsel = RW'(r);
				any_free = 1'b1;
			end
		end
		o1_ctz = ctz64(top_q[rsel]);
	end

	// Region containment check for the region under reg_q
	logic [63:0] diff;
	logic [18:0] eff;
	logic        holds_now;
	logic [19:0] run_end;
	always_comb begin
		eff = (frames_q[reg_q] > FRAMES_MAX) ? FRAMES_MAX : frames_q[reg_q];
		diff = addr_q - base_q[reg_q];
		holds_now = (addr_q >= base_q[reg_q]) && (diff[63:PAGE_SHIFT] < 52'(eff));
		run_end = 20'(frame_q[reg_q]) + 20'(count_q);
	end

	// Per-frame read-modify-write of the run operations
	logic [5:0]  f1, f2, f3;
	logic [63:0] mid_cur, leaf_cur, mid_new, leaf_new, top_new;
	always_comb begin
		f1 = cur_q[17:12];
		f2 = cur_q[11:6];
		f3 = cur_q[5:0];
		mid_cur = top_q[reg_q][f1] ? mid_rd : 64'd0;
		leaf_cur = mid_cur[f2] ? leaf_rd : 64'd0;
		top_new = top_q[reg_q];
		if (func_q == FUNC_FREE) begin
			leaf_new = leaf_cur | (64'd1 << f3);
			mid_new = mid_cur | (64'd1 << f2);
			top_new[f1] = 1'b1;
		end else begin
			leaf_new = leaf_cur & ~(64'd1 << f3);
			mid_new = (leaf_new == 64'd0) ? (mid_cur & ~(64'd1 << f2)) : mid_cur;
			if (mid_new == 64'd0) begin
				top_new[f1] = 1'b0;
			end
		end
	end

	// Allocate run length and writeback values
	logic [6:0]  n_zero, n_lim, n_cap;
	logic [63:0] run_mask, m3_new, m2_new;
	logic [5:0]  o2_now;
	logic [6:0]  o2_ctz, o3_ctz;
	always_comb begin
		n_zero = ctz64(~m3_q >> o3_q);
		n_lim = 7'd64 - {1'b0, o3_q};
		n_cap = (n_zero > n_lim) ? n_lim : n_zero;
		if (19'(n_cap) > count_q) begin
			n_cap = count_q[6:0];
		end
		run_mask = n_q[6] ? {64{1'b1}} : ((64'd1 << n_q[5:0]) - 64'd1);
		m3_new = m3_q & ~(run_mask << o3_q);
		m2_new = (m3_new == 64'd0) ? (m2_q & ~(64'd1 << o2_q)) : m2_q;
		o2_ctz = ctz64(mid_rd);
		o2_now = o2_ctz[5:0];
		o3_ctz = ctz64(leaf_rd);
	end

	always_comb begin
		mid_we = 1'b0;
		leaf_we = 1'b0;
		mid_waddr = MAW'({reg_q, f1});
		leaf_waddr = LAW'({reg_q, f1, f2});
		mid_wdata = mid_new;
		leaf_wdata = leaf_new;
		mid_raddr = MAW'({reg_q, f1});
		leaf_raddr = LAW'({reg_q, f1, f2});
		case (state_q)
			S_RUN_WB: begin
				mid_we = 1'b1;
				leaf_we = 1'b1;
			end
			S_A_MID: begin
				mid_raddr = MAW'({reg_q, o1_q});
			end
			S_A_LEAF: begin
				leaf_raddr = LAW'({reg_q, o1_q, o2_now});
			end
			S_DONE: begin
				if (func_q == FUNC_ALLOC && res_status_q == ST_OK && state_q == S_DONE) begin
					mid_we = 1'b0;
				end
			end
			default: begin
			end
		endcase
		if (state_q == S_A_RUN) begin
			// writeback happens on the cycle after n is known
			mid_we = 1'b0;
		end
		if (alloc_wb) begin
			mid_we = 1'b1;
			leaf_we = 1'b1;
			mid_waddr = MAW'({reg_q, o1_q});
			leaf_waddr = LAW'({reg_q, o1_q, o2_q});
			mid_wdata = m2_new;
			leaf_wdata = m3_new;
		end
	end

	logic out_free;
	assign out_free = !out_valid_q || rsp.ready;

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = out_valid_q;
	assign rsp.status = out_status_q;
	assign rsp.granted_address = out_addr_q;
	assign rsp.granted_frames = out_frames_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < REGIONS; r++) begin
				base_q[r] <= 64'd0;
				frames_q[r] <= 19'd0;
			end
		end else if (cfg.valid && 32'(cfg.index) < CFG_REGS) begin
			for (int r = 0; r < REGIONS; r++) begin
				if (cfg.index[3:1] == 3'(r)) begin
					if (cfg.index[0]) begin
						frames_q[r] <= cfg.data[18:0];
					end else begin
						base_q[r] <= cfg.data;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			alloc_wb_q <= 1'b0;
			reg_q <= '0;
			holds_q <= '0;
			for (int r = 0; r < REGIONS; r++) begin
				top_q[r] <= 64'd0;
			end
		end else begin
			alloc_wb_q <= (state_q == S_A_RUN);
			if (state_q == S_DONE && !alloc_wb_q && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						func_q <= req.func;
						addr_q <= req.byte_address;
						count_q <= req.frame_count;
						res_addr_q <= 64'd0;
						res_frames_q <= 7'd0;
						holds_q <= '0;
						case (req.func)
							FUNC_ALLOC: begin
								if (any_free) begin
									res_status_q <= ST_OK;
									reg_q <= rsel;
									o1_q <= o1_ctz[5:0];
									state_q <= S_A_MID;
								end else begin
									res_status_q <= ST_NO_FREE;
									reg_q <= '0;
									state_q <= S_DONE;
								end
							end
							FUNC_FREE, FUNC_USED: begin
								reg_q <= '0;
								if (req.byte_address[PAGE_SHIFT-1:0] != '0) begin
									res_status_q <= ST_MISALIGNED;
									state_q <= S_DONE;
								end else if (req.frame_count == 19'd0) begin
									res_status_q <= ST_OK;
									state_q <= S_DONE;
								end else begin
									res_status_q <= ST_OK;
									state_q <= S_CHK;
								end
							end
							default: begin
								reg_q <= '0;
								res_status_q <= ST_OK;
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_CHK: begin
					holds_q[reg_q] <= holds_now;
					frame_q[reg_q] <= diff[PAGE_SHIFT+17:PAGE_SHIFT];
					if (reg_q == REG_LAST) begin
						reg_q <= '0;
						state_q <= S_CHK_END;
					end else begin
						reg_q <= reg_q + 1'b1;
					end
				end
				S_CHK_END: begin
					if (holds_q[reg_q] && run_end > 20'(eff)) begin
						res_status_q <= ST_PAST_END;
						state_q <= S_DONE;
					end else if (reg_q == REG_LAST) begin
						reg_q <= '0;
						if (holds_q == '0) begin
							res_status_q <= ST_OUTSIDE;
							state_q <= S_DONE;
						end else begin
							state_q <= S_RUN_SEL;
						end
					end else begin
						reg_q <= reg_q + 1'b1;
					end
				end
				S_RUN_SEL: begin
					if (holds_q[reg_q]) begin
						cur_q <= frame_q[reg_q];
						left_q <= count_q;
						state_q <= S_RUN_RD;
					end else if (reg_q == REG_LAST) begin
						state_q <= S_DONE;
					end else begin
						reg_q <= reg_q + 1'b1;
					end
				end
				S_RUN_RD: begin
					state_q <= S_RUN_WB;
				end
				S_RUN_WB: begin
					top_q[reg_q] <= top_new;
					if (left_q == 19'd1) begin
						if (reg_q == REG_LAST) begin
							state_q <= S_DONE;
						end else begin
							reg_q <= reg_q + 1'b1;
							state_q <= S_RUN_SEL;
						end
					end else begin
						cur_q <= cur_q + 18'd1;
						left_q <= left_q - 19'd1;
						state_q <= S_RUN_RD;
					end
				end
				S_A_MID: begin
					state_q <= S_A_LEAF;
				end
				S_A_LEAF: begin
					m2_q <= mid_rd;
					o2_q <= o2_now;
					state_q <= S_A_O3;
				end
				S_A_O3: begin
					m3_q <= leaf_rd;
					o3_q <= o3_ctz[5:0];
					state_q <= S_A_RUN;
				end
				S_A_RUN: begin
					n_q <= n_cap;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (alloc_wb_q) begin
						// leaf and mid words are written back this cycle
						if (m2_new == 64'd0) begin
							top_q[reg_q][o1_q] <= 1'b0;
						end
						res_addr_q <= base_q[reg_q] + {34'd0, o1_q, o2_q, o3_q, 12'd0};
						res_frames_q <= n_q;
					end else if (out_free) begin
						out_status_q <= res_status_q;
						out_addr_q <= res_addr_q;
						out_frames_q <= res_frames_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The chosen mid word must have a free leaf below it
	a_mid_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_A_LEAF |-> mid_rd != 64'd0)
		else $error("allocate found an empty mid word under a set top bit");

	// The chosen leaf word must have its lowest free bit set
	a_leaf_bit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_A_RUN |-> m3_q[o3_q])
		else $error("allocate leaf word lacks the selected free bit");

	// A grant never runs past the end of its leaf word
	a_run_in_word: assert property (@(posedge clk) disable iff (!arst_n)
		alloc_wb_q |-> (8'(n_q) + 8'(o3_q)) <= 8'd64)
		else $error("allocate run crosses a leaf word boundary");

	// A finished result reaches the output register once it is free
	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && !alloc_wb_q && out_free |=> out_valid_q)
		else $error("result not presented after completion");

endmodule

@@ tb/tb_hierarchical_bitmap_frame_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// tb_hierarchical_bitmap_frame_allocator_unit: self-checking bench of the allocator
// Drives allocate, free and mark-used requests through directed and random
// phases over several region layouts. A bench-side copy of the three-level
// maps predicts every response, and the monitor checks each one in order.
// ----------------------------------------------------------------------------
module tb_hierarchical_bitmap_frame_allocator_unit
	import hbfa_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NREG = 4;
	localparam int IDLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 400;
	localparam int CALM_TAIL = 150;
	localparam longint unsigned MAX_FRAMES = 262144;

	typedef struct packed {
		logic [1:0]  func;
		logic [63:0] addr;
		logic [18:0] count;
	} frame_req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] gaddr;
		logic [6:0]  gframes;
	} frame_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	hbfa_cfg_if cfg();
	hbfa_req_if req();
	hbfa_rsp_if rsp();

	hierarchical_bitmap_frame_allocator_unit #(.REGIONS(NREG)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg.sink),
		.req(req.sink),
		.rsp(rsp.source)
	);

	always #1 clk = ~clk;

	// shadow registers and maps
	logic [63:0] sh_base[NREG];
	logic [18:0] sh_frames[NREG];
	logic [63:0] sh_top[NREG];
	logic [63:0] sh_mid[NREG*64];
	logic [63:0] sh_leaf[NREG*4096];

	frame_req_t pending[$];
	frame_rsp_t expected_rsp[$];
	frame_req_t cur_req;

	int errors = 0;
	int n_alloc = 0, n_free = 0, n_mark = 0, n_other = 0, n_writes = 0;
	int req_gap = 0;
	int rsp_stall = 0;
	int hold_cnt = 0;
	int idle_cycles = 0;
	bit pressure_req = 1'b0;
	bit pressure_done = 1'b0;
	bit last_phase = 1'b0;

	function automatic int low_bit(logic [63:0] v);
		for (int i = 0; i < 64; i++) begin
			if (v[i]) return i;
		end
		return 64;
	endfunction

	function automatic longint unsigned eff_frames(int r);
		return (sh_frames[r] > MAX_FRAMES) ? MAX_FRAMES : longint'(sh_frames[r]);
	endfunction

	function automatic bit holds(int r, logic [63:0] a, output longint unsigned fr);
		fr = 0;
		if (a < sh_base[r]) return 1'b0;
		fr = (a - sh_base[r]) >> PAGE_SHIFT;
		return fr < eff_frames(r);
	endfunction

	function automatic void mark_frame(int r, longint unsigned f, bit freeing);
		int o1, o2, o3, li;
		o1 = int'((f >> 12) & 63);
		o2 = int'((f >> 6) & 63);
		o3 = int'(f & 63);
		li = r * 4096 + o1 * 64 + o2;
		if (freeing) begin
			sh_top[r] |= 64'd1 << o1;
			sh_mid[r*64+o1] |= 64'd1 << o2;
			sh_leaf[li] |= 64'd1 << o3;
		end else begin
			sh_leaf[li] &= ~(64'd1 << o3);
			if (sh_leaf[li] == 0) begin
				sh_mid[r*64+o1] &= ~(64'd1 << o2);
				if (sh_mid[r*64+o1] == 0) sh_top[r] &= ~(64'd1 << o1);
			end
		end
	endfunction

	function automatic frame_rsp_t predict_alloc(logic [18:0] want);
		frame_rsp_t p;
		int o1, o2, o3, n, li;
		logic [63:0] m2, m3, runm;
		longint unsigned fr;
		p = '0;
		p.status = ST_NO_FREE;
		for (int r = NREG - 1; r >= 0; r--) begin
			if (sh_top[r] == 0) continue;
			o1 = low_bit(sh_top[r]) & 63;
			m2 = sh_mid[r*64+o1];
			o2 = low_bit(m2) & 63;
			li = r * 4096 + o1 * 64 + o2;
			m3 = sh_leaf[li];
			o3 = low_bit(m3) & 63;
			fr = (longint'(o1) << 12) + (longint'(o2) << 6) + o3;
			n = low_bit(~m3 >> o3);
			if (n > 64 - o3) n = 64 - o3;
			if (n > int'(want)) n = int'(want);
			p.status = ST_OK;
			p.gaddr = sh_base[r] + (64'(fr) << PAGE_SHIFT);
			p.gframes = 7'(n);
			runm = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
			m3 &= ~(runm << o3);
			sh_leaf[li] = m3;
			if (m3 == 0) begin
				m2 &= ~(64'd1 << o2);
				sh_mid[r*64+o1] = m2;
				if (m2 == 0) sh_top[r] &= ~(64'd1 << o1);
			end
			return p;
		end
		return p;
	endfunction

	function automatic logic [2:0] walk_run(bit freeing, logic [63:0] a, logic [18:0] cnt);
		bit any;
		longint unsigned fr;
		any = 1'b0;
		if (a[PAGE_SHIFT-1:0] != 0) return ST_MISALIGNED;
		if (cnt == 0) return ST_OK;
		for (int r = 0; r < NREG; r++) begin
			if (!holds(r, a, fr)) continue;
			any = 1'b1;
			if (fr + cnt > eff_frames(r)) return ST_PAST_END;
		end
		if (!any) return ST_OUTSIDE;
		for (int r = 0; r < NREG; r++) begin
			if (!holds(r, a, fr)) continue;
			for (longint unsigned k = 0; k < cnt; k++) mark_frame(r, fr + k, freeing);
		end
		return ST_OK;
	endfunction

	function automatic frame_rsp_t predict_rsp(frame_req_t q);
		frame_rsp_t p;
		p = '0;
		case (q.func)
			FUNC_ALLOC: p = predict_alloc(q.count);
			FUNC_FREE: p.status = walk_run(1'b1, q.addr, q.count);
			FUNC_USED: p.status = walk_run(1'b0, q.addr, q.count);
			default: p.status = ST_OK;
		endcase
		return p;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got 0x%0h, want 0x%0h", what, got, want);
		errors++;
	endtask

	task automatic push(logic [1:0] f, logic [63:0] a, logic [18:0] c);
		frame_req_t q;
		q.func = f;
		q.addr = a;
		q.count = c;
		pending.push_back(q);
	endtask

	function automatic logic [63:0] frame_addr(int r, longint unsigned f);
		return sh_base[r] + (64'(f) << PAGE_SHIFT);
	endfunction

	task automatic write_reg(logic [3:0] idx, logic [63:0] data);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= data;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		if (idx < CFG_REGS) begin
			if (idx[0]) sh_frames[idx>>1] = data[18:0];
			else sh_base[idx>>1] = data;
		end
		n_writes++;
	endtask

	// check on the falling edge, once every driven value has settled
	task automatic drain();
		@(negedge clk);
		while (pending.size() != 0 || req.valid || expected_rsp.size() != 0) @(negedge clk);
		repeat (8) @(posedge clk);
	endtask

	// allocations and mostly well-formed runs inside a region, with some noise
	task automatic add_random(int n);
		int r, pick;
		longint unsigned ef, f, c;
		logic [63:0] a;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			r = $urandom_range(0, NREG - 1);
			ef = eff_frames(r);
			if (pick < 35) begin
				c = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 19'h7ffff)
					: $urandom_range(0, 70);
				push(FUNC_ALLOC, {$urandom, $urandom}, 19'(c));
			end else if (pick < 80 && ef != 0) begin
				f = $urandom_range(0, int'(ef - 1));
				c = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 200 : 40);
				if ($urandom_range(0, 9) == 0) c = ef - f + $urandom_range(1, 5);
				push((pick < 60) ? FUNC_FREE : FUNC_USED, frame_addr(r, f), 19'(c));
			end else begin
				a = {$urandom, $urandom};
				c = $urandom_range(0, 19'h7ffff);
				if (c > 64) a[0] = 1'b1;
				push(2'($urandom_range(0, 3)), a, 19'(c));
			end
		end
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.func <= FUNC_ALLOC;
			req.byte_address <= '0;
			req.frame_count <= '0;
		end else begin
			if (req.valid && req.ready) begin
				expected_rsp.push_back(predict_rsp(cur_req));
				case (cur_req.func)
					FUNC_ALLOC: n_alloc++;
					FUNC_FREE: n_free++;
					FUNC_USED: n_mark++;
					default: n_other++;
				endcase
				if (!(last_phase && pending.size() < CALM_TAIL) && $urandom_range(0, 4) == 0)
					req_gap = $urandom_range(1, 17);
			end
			if (!req.valid || req.ready) begin
				if (req_gap > 0) begin
					req_gap--;
					req.valid <= 1'b0;
				end else if (pending.size() != 0) begin
					cur_req = pending.pop_front();
					req.func <= cur_req.func;
					req.byte_address <= cur_req.addr;
					req.frame_count <= cur_req.count;
					req.valid <= 1'b1;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// response ready with random stalls and one long hold
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt--;
			rsp.ready <= 1'b0;
		end else if (pressure_req && !pressure_done) begin
			pressure_done = 1'b1;
			hold_cnt = HOLD_CYCLES;
			rsp.ready <= 1'b0;
		end else if (rsp_stall > 0) begin
			rsp_stall--;
			rsp.ready <= 1'b0;
		end else if (!(last_phase && pending.size() < CALM_TAIL) && $urandom_range(0, 9) == 0) begin
			rsp_stall = $urandom_range(0, 16);
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	// response monitor
	always @(posedge clk) begin
		frame_rsp_t e;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_rsp.size() == 0) begin
				report("unexpected response status", 64'(rsp.status), 64'(ST_OK));
			end else begin
				e = expected_rsp.pop_front();
				if (rsp.status !== e.status) report("status", 64'(rsp.status), 64'(e.status));
				if (rsp.granted_address !== e.gaddr)
					report("granted_address", rsp.granted_address, e.gaddr);
				if (rsp.granted_frames !== e.gframes)
					report("granted_frames", 64'(rsp.granted_frames), 64'(e.gframes));
			end
		end
	end

	// watchdog on cycles with no handshake anywhere
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout after %0d idle cycles", idle_cycles);
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		for (int r = 0; r < NREG; r++) begin
			sh_base[r] = '0;
			sh_frames[r] = '0;
			sh_top[r] = '0;
		end
		foreach (sh_mid[i]) sh_mid[i] = '0;
		foreach (sh_leaf[i]) sh_leaf[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// small layout for the directed part
		write_reg(0, 64'h0);
		write_reg(1, 64'd300);
		write_reg(2, 64'h0000_0010_0000_0000);
		write_reg(3, 64'd4166);
		write_reg(4, 64'h0000_0000_2000_0000);
		write_reg(5, 64'd0);
		write_reg(6, 64'hFFFF_FFFF_FFFF_8000);
		write_reg(7, 64'd8);
		write_reg(9, 64'hDEAD);

		push(FUNC_ALLOC, '0, 19'd1);
		push(FUNC_FREE, 64'h1, 19'd5);
		push(FUNC_USED, 64'hFFFF_FFFF_FFFF_FFFF, 19'h7ffff);
		push(FUNC_FREE, 64'h0, 19'd0);
		push(FUNC_FREE, 64'h0000_5000_0000_0000, 19'd1);
		push(FUNC_FREE, 64'h0, 19'd301);
		push(FUNC_FREE, 64'h0, 19'd100);
		push(FUNC_ALLOC, '0, 19'd0);
		push(FUNC_ALLOC, '0, 19'd5);
		push(FUNC_ALLOC, '0, 19'h7ffff);
		push(FUNC_USED, 64'd10 << 12, 19'd3);
		push(FUNC_ALLOC, '0, 19'd64);
		push(FUNC_FREE, 64'hFFFF_FFFF_FFFF_8000, 19'd8);
		push(FUNC_ALLOC, '0, 19'd3);
		push(FUNC_FREE, 64'h0000_0010_0000_0000, 19'd4096);
		push(FUNC_ALLOC, '0, 19'd64);
		push(FUNC_USED, 64'h0000_0010_0000_0000, 19'd4096);
		push(2'd3, 64'hFFFF_FFFF_FFFF_F000, 19'h7ffff);
		push(FUNC_FREE, 64'd299 << 12, 19'd1);
		push(FUNC_FREE, 64'd299 << 12, 19'd2);
		push(FUNC_USED, 64'd299 << 12, 19'd1);
		push(FUNC_ALLOC, '0, 19'd1);
		drain();

		// overlapping regions, random sizes
		write_reg(0, 64'h0);
		write_reg(1, 64'd5000);
		write_reg(2, 64'd2000 << 12);
		write_reg(3, {45'($urandom), 19'd3000});
		write_reg(4, {$urandom, $urandom} & ~64'hFFF);
		write_reg(5, 64'($urandom_range(1, 262144)));
		write_reg(6, {$urandom, $urandom} & ~64'hFFF);
		write_reg(7, 64'h7ffff);
		add_random(200);
		pressure_req = 1'b1;
		add_random(200);
		drain();

		// extremes: empty region, full-size regions, top of the address space
		write_reg(0, 64'h0);
		write_reg(1, 64'd0);
		write_reg(2, 64'h8000_0000_0000_0000);
		write_reg(3, 64'd262144);
		write_reg(4, 64'hFFFF_FFFF_FFFF_F000);
		write_reg(5, 64'd262144);
		write_reg(6, 64'hFFFF_FFFF_FFFF_F000);
		write_reg(7, 64'd1);
		last_phase = 1'b1;
		add_random(450);
		drain();

		$display("covered %0d requests: %0d allocate, %0d free, %0d mark used, %0d other",
			n_alloc + n_free + n_mark + n_other, n_alloc, n_free, n_mark, n_other);
		$display("%0d register writes over three region layouts, %0d mismatches",
			n_writes, errors);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
